// ----- sv/btc_pkg.sv -----
package btc_pkg;

    localparam int BYTE_W  = 8;
    localparam int ENTRY_W = 3;
    localparam int KEY_W   = 18;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [KEY_W-1:0] KEY_RESET = 18'd189896;

    // register select, taken from paddr[2]
    typedef enum logic
    {
        REG_KEY_MAP      = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } reg_sel_t;

endpackage

// ----- sv/btc_store.sv -----
module btc_store #(
    parameter int AW = 4
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [btc_pkg::BYTE_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [btc_pkg::BYTE_W-1:0] rdata
);

    logic [btc_pkg::BYTE_W-1:0] mem [(1 << AW)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/btc_fill.sv -----
module btc_fill #(
    parameter  int BLOCK_LEN = 6,
    localparam int IDX_W     = $clog2(BLOCK_LEN)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [btc_pkg::BYTE_W-1:0] data_byte,
    input  logic                       end_of_message,
    input  logic [1:0]                 bank_busy,
    output logic                       mem_we,
    output logic [IDX_W:0]             mem_waddr,
    output logic [btc_pkg::BYTE_W-1:0] mem_wdata,
    output logic                       push,
    output logic                       push_bank,
    output logic [IDX_W-1:0]           push_last_idx,
    output logic                       push_eom
);

    logic [IDX_W-1:0] fill_reg;
    logic             wbank_reg;
    logic             accept;
    logic             block_end;

    // bank still draining: hold off the writer
    assign in_stall  = bank_busy[wbank_reg];
    assign accept    = in_valid && !in_stall;
    assign block_end = (fill_reg == IDX_W'(BLOCK_LEN - 1)) || end_of_message;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            wbank_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (block_end)
            begin
                fill_reg  <= '0;
                wbank_reg <= ~wbank_reg;
            end
            else
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    assign mem_we        = accept;
    assign mem_waddr     = {wbank_reg, fill_reg};
    assign mem_wdata     = data_byte;
    assign push          = accept && block_end;
    assign push_bank     = wbank_reg;
    assign push_last_idx = fill_reg;
    assign push_eom      = end_of_message;

endmodule

// ----- sv/btc_reader.sv -----
module btc_reader #(
    parameter  int BLOCK_LEN = 6,
    localparam int IDX_W     = $clog2(BLOCK_LEN)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    input  logic [IDX_W-1:0]           job_last_idx,
    input  logic                       job_eom,
    input  logic [btc_pkg::KEY_W-1:0]  key_map,
    input  logic                       decrypt_mode,
    output logic                       rbank,
    output logic                       done,
    output logic                       rd_en,
    output logic [IDX_W:0]             rd_addr,
    input  logic [btc_pkg::BYTE_W-1:0] rd_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [btc_pkg::BYTE_W-1:0] out_byte,
    output logic                       run_last,
    output logic                       message_last
);

    localparam int ENTRY_W = btc_pkg::ENTRY_W;
    localparam int EXT_W   = (BLOCK_LEN * ENTRY_W > btc_pkg::KEY_W) ?
                             BLOCK_LEN * ENTRY_W : btc_pkg::KEY_W;

    logic             rbank_reg;
    logic [IDX_W-1:0] pos_reg;

    logic             s1_valid_reg;
    logic             s1_zero_reg;
    logic             s1_run_last_reg;
    logic             s1_msg_last_reg;

    logic             out_valid_reg;
    logic [btc_pkg::BYTE_W-1:0] out_byte_reg;
    logic             run_last_reg;
    logic             message_last_reg;

    logic [EXT_W-1:0]   key_ext;
    logic [ENTRY_W-1:0] k_enc;
    logic               found;
    logic [IDX_W-1:0]   inv_idx;
    logic               passthru;
    logic               last;
    logic               src_zero;
    logic [IDX_W-1:0]   src_idx;
    logic               out_load;
    logic               s1_ready;
    logic               issue;

    // positions beyond the key register read as entry 0
    always_comb
    begin
        key_ext = EXT_W'(key_map);
        k_enc   = key_ext[int'(pos_reg) * ENTRY_W +: ENTRY_W];
        found   = 1'b0;
        inv_idx = '0;
        // lowest matching position wins
        for (int n = BLOCK_LEN - 1; n >= 0; n--)
        begin
            if (key_ext[n * ENTRY_W +: ENTRY_W] == ENTRY_W'(pos_reg))
            begin
                found   = 1'b1;
                inv_idx = IDX_W'(n);
            end
        end
        passthru = (job_last_idx != IDX_W'(BLOCK_LEN - 1));
        last     = (pos_reg == job_last_idx);
        if (passthru)
        begin
            src_zero = 1'b0;
            src_idx  = pos_reg;
        end
        else if (!decrypt_mode)
        begin
            src_zero = ({1'b0, k_enc} >= (ENTRY_W + 1)'(BLOCK_LEN));
            src_idx  = k_enc[IDX_W-1:0];
        end
        else
        begin
            src_zero = !found;
            src_idx  = inv_idx;
        end
    end

    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_ready = !s1_valid_reg || out_load;
    assign issue    = job_valid && s1_ready;

    assign rbank   = rbank_reg;
    assign done    = issue && last;
    assign rd_en   = issue;
    assign rd_addr = {rbank_reg, src_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbank_reg     <= 1'b0;
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                if (last)
                begin
                    pos_reg   <= '0;
                    rbank_reg <= ~rbank_reg;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end

            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_zero_reg     <= src_zero;
            s1_run_last_reg <= last;
            s1_msg_last_reg <= last && job_eom;
        end
        if (out_load)
        begin
            out_byte_reg     <= s1_zero_reg ? '0 : rd_data;
            run_last_reg     <= s1_run_last_reg;
            message_last_reg <= s1_msg_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign run_last     = run_last_reg;
    assign message_last = message_last_reg;

endmodule

// ----- sv/block_transposition_cipher.sv -----
// Block transposition cipher, one byte per cycle in and out absent stalls.
//
// Input channel (in_valid / in_stall): data_byte plus end_of_message. Bytes
// gather into blocks of BLOCK_LEN. A full block leaves reordered by key_map
// (or its inverse when decrypt_mode is set); a short block closed by
// end_of_message leaves in arrival order.
// Output channel (out_valid / out_stall): out_byte, run_last on the last byte
// of each block, message_last on the last byte of a message.
// Config: APB, key_map at 0x0, decrypt_mode at 0x4; write only while idle.
//
// A block's first byte leaves through the store read and then the output
// register once the request closing it is accepted. Throughput is one byte
// per cycle sustained while the output is not stalled: the block store holds
// two banks, one filling while the other drains through a single read port.
// in_stall rises only while both banks hold blocks not yet drained.
// A stall on the output holds the output register, then the read stage,
// then the bank sequencer; nothing is dropped.
// Reset clears fill position, bank ownership and the output pipe and loads
// the default key; the store itself needs no clearing.
module block_transposition_cipher #(
    parameter int BLOCK_LEN = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [btc_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                end_of_message,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [btc_pkg::BYTE_W-1:0]          out_byte,
    output logic                                run_last,
    output logic                                message_last,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btc_pkg::ADDR_W-1:0]          paddr,
    input  logic [btc_pkg::DATA_W-1:0]          pwdata,
    output logic [btc_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int IDX_W = $clog2(BLOCK_LEN);

    logic [btc_pkg::KEY_W-1:0] key_map_reg;
    logic                      decrypt_mode_reg;
    logic                      cfg_wr;
    btc_pkg::reg_sel_t         sel;

    logic [1:0]       bank_busy_reg;
    logic [1:0]       bank_busy_next;
    logic [IDX_W-1:0] job_last_reg [2];
    logic             job_eom_reg  [2];

    logic                       mem_we;
    logic [IDX_W:0]             mem_waddr;
    logic [btc_pkg::BYTE_W-1:0] mem_wdata;
    logic                       push;
    logic                       push_bank;
    logic [IDX_W-1:0]           push_last_idx;
    logic                       push_eom;

    logic                       rbank;
    logic                       done;
    logic                       rd_en;
    logic [IDX_W:0]             rd_addr;
    logic [btc_pkg::BYTE_W-1:0] rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign sel    = btc_pkg::reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_map_reg      <= btc_pkg::KEY_RESET;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (sel)
                btc_pkg::REG_KEY_MAP:      key_map_reg      <= pwdata[btc_pkg::KEY_W-1:0];
                btc_pkg::REG_DECRYPT_MODE: decrypt_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            btc_pkg::REG_KEY_MAP:      prdata = btc_pkg::DATA_W'(key_map_reg);
            btc_pkg::REG_DECRYPT_MODE: prdata = btc_pkg::DATA_W'(decrypt_mode_reg);
            default:                   prdata = '0;
        endcase
    end

    // bank ownership: set when the writer closes a block, cleared when the
    // reader issues its last read of that bank
    always_comb
    begin
        bank_busy_next = bank_busy_reg;
        if (push)
        begin
            bank_busy_next[push_bank] = 1'b1;
        end
        if (done)
        begin
            bank_busy_next[rbank] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_busy_reg <= 2'b00;
        end
        else
        begin
            bank_busy_reg <= bank_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_last_reg[push_bank] <= push_last_idx;
            job_eom_reg[push_bank]  <= push_eom;
        end
    end

    btc_fill #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_fill (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .bank_busy      (bank_busy_reg),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .push           (push),
        .push_bank      (push_bank),
        .push_last_idx  (push_last_idx),
        .push_eom       (push_eom)
    );

    btc_store #(
        .AW (IDX_W + 1)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    btc_reader #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_reader (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (bank_busy_reg[rbank]),
        .job_last_idx (job_last_reg[rbank]),
        .job_eom      (job_eom_reg[rbank]),
        .key_map      (key_map_reg),
        .decrypt_mode (decrypt_mode_reg),
        .rbank        (rbank),
        .done         (done),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .message_last (message_last)
    );

    a_push_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !bank_busy_reg[push_bank])
        else $error("block closed into a bank still draining");

    a_done_busy_bank: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> bank_busy_reg[rbank])
        else $error("reader finished a bank it did not own");

    a_no_write_read_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && rd_en) |-> (mem_waddr[IDX_W] != rd_addr[IDX_W]))
        else $error("write and read hit the same bank");

    a_msg_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && message_last) |-> run_last)
        else $error("message end not on a block end");

endmodule
